// ===== hdl/qfmd_pkg.sv =====
// Package for the quadrature FM demodulator: sizes, function codes,
// register indexes and the CORDIC arctangent table. No dependencies.
package qfmd_pkg;
	localparam int Taps = 63;
	localparam int TapW = 6;
	localparam int CordicSteps = 22;
	localparam int StepW = 5;

	localparam logic FUNC_COEF   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [0:0] REG_PHASE_STEP  = 1'b0;
	localparam logic [0:0] REG_OUTPUT_GAIN = 1'b1;

	localparam logic signed [25:0] HalfTurn = 26'sd8388608;
	localparam logic signed [23:0] QuarterTurn = 24'sd4194304;

	typedef logic signed [17:0] coef_t;
	typedef logic signed [17:0] tap_t;

	function automatic logic signed [23:0] atan_turns(input logic [StepW-1:0] i);
		logic signed [23:0] r;
		begin
			case (i)
				5'd0: r = 24'sd2097152;
				5'd1: r = 24'sd1238021;
				5'd2: r = 24'sd654136;
				5'd3: r = 24'sd332050;
				5'd4: r = 24'sd166669;
				5'd5: r = 24'sd83416;
				5'd6: r = 24'sd41718;
				5'd7: r = 24'sd20860;
				5'd8: r = 24'sd10430;
				5'd9: r = 24'sd5215;
				5'd10: r = 24'sd2608;
				5'd11: r = 24'sd1304;
				5'd12: r = 24'sd652;
				5'd13: r = 24'sd326;
				5'd14: r = 24'sd163;
				5'd15: r = 24'sd81;
				5'd16: r = 24'sd41;
				5'd17: r = 24'sd20;
				5'd18: r = 24'sd10;
				5'd19: r = 24'sd5;
				5'd20: r = 24'sd3;
				5'd21: r = 24'sd1;
				default: r = 24'sd0;
			endcase
			return r;
		end
	endfunction
endpackage

// ===== hdl/qfmd_if.sv =====
// Valid/ready channel interfaces for the demodulator.
// Does not depend on qfmd_pkg.
interface qfmd_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [5:0] coef_index;
	logic signed [17:0] coef_value;
	logic signed [15:0] sample;
	modport source(output valid, func, coef_index, coef_value, sample, input ready);
	modport sink(input valid, func, coef_index, coef_value, sample, output ready);
endinterface

interface qfmd_out_if;
	logic valid;
	logic ready;
	logic [15:0] pixel_level;
	modport source(output valid, pixel_level, input ready);
	modport sink(input valid, pixel_level, output ready);
endinterface

interface qfmd_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/quadrature_fm_demodulator_core.sv =====
// Quadrature FM demodulator: mixer CORDIC, two FIRs sharing one MAC over
// delay-line memories, atan2 CORDIC, gain and saturation.
// One item at a time: a new sample is taken only in idle, after the shared MAC
// has walked both filters and the level has been offered at the output (the atan
// rotation is skipped for a zero product); a stalled level holds the next sample
// before the output. Coefficient items are written from idle without leaving it.
// Reset clears control and the two delay lines by a clearing pass over every tap; no sample is taken meanwhile.
module quadrature_fm_demodulator_core (
	input logic clk,
	input logic arst_n,
	qfmd_in_if.sink in_ch,
	qfmd_out_if.source out_ch,
	qfmd_cfg_if.sink cfg
);
	import qfmd_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MIX   = 4'd2;
	localparam logic [3:0] ST_PROD  = 4'd3;
	localparam logic [3:0] ST_MAC   = 4'd4;
	localparam logic [3:0] ST_FIRO  = 4'd5;
	localparam logic [3:0] ST_CMUL  = 4'd6;
	localparam logic [3:0] ST_CADD  = 4'd7;
	localparam logic [3:0] ST_ATAN  = 4'd8;
	localparam logic [3:0] ST_GAIN  = 4'd9;
	localparam logic [3:0] ST_LVL   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0] state_q;
	logic [31:0] phase_step_q, mixer_phase_q;
	logic [15:0] output_gain_q;
	logic [TapW-1:0] wpos_q, tap_q, ridx_q;
	logic [StepW-1:0] step_q;
	logic [TapW:0] macn_q;
	logic chan_q;
	logic signed [15:0] sample_q;

	// memories
	coef_t coef_mem [Taps];
	tap_t iline_mem [Taps];
	tap_t qline_mem [Taps];
	coef_t coef_rd;
	tap_t iline_rd, qline_rd;
	logic line_we;
	logic [TapW-1:0] line_waddr;
	tap_t iline_wd, qline_wd;

	// cordic
	logic signed [25:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic signed [65:0] ax_q, ay_q;
	logic signed [25:0] az_q;
	logic signed [15:0] cos_q, sin_q;
	logic signed [47:0] acc_q;
	logic signed [23:0] ci_q, cq_q, pi_q, pq_q;
	logic signed [47:0] m0_q, m1_q, m2_q, m3_q;
	logic signed [63:0] re_q, im_q;
	logic signed [40:0] gp_q;
	logic [15:0] lvl_q;
	logic out_valid_q;

	logic in_acc, cfg_acc;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;
	assign cfg_acc = cfg.valid;
	assign out_ch.valid = out_valid_q;
	assign out_ch.pixel_level = lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			output_gain_q <= 16'd256;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_PHASE_STEP: phase_step_q <= cfg.data;
				REG_OUTPUT_GAIN: output_gain_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// coefficient memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.func == FUNC_COEF && in_ch.coef_index < TapW'(Taps))
			coef_mem[in_ch.coef_index] <= in_ch.coef_value;
		coef_rd <= coef_mem[tap_q];
	end

	always_ff @(posedge clk) begin
		if (line_we) begin
			iline_mem[line_waddr] <= iline_wd;
			qline_mem[line_waddr] <= qline_wd;
		end
		iline_rd <= iline_mem[ridx_q];
		qline_rd <= qline_mem[ridx_q];
	end

	// mixer product, (s*trig + 2^13) >>> 14
	logic signed [31:0] pi_full, pq_full;
	assign pi_full = 32'(sample_q) * 32'(cos_q) + 32'sd8192;
	assign pq_full = 32'(sample_q) * 32'(sin_q) + 32'sd8192;

	always_comb begin
		line_we = 1'b0;
		line_waddr = wpos_q;
		iline_wd = tap_t'(pi_full >>> 14);
		qline_wd = tap_t'(pq_full >>> 14);
		if (state_q == ST_CLEAR) begin
			line_we = 1'b1;
			iline_wd = '0;
			qline_wd = '0;
		end else if (state_q == ST_PROD) begin
			line_we = 1'b1;
		end
	end

	// mixer rotation step
	logic signed [25:0] mx_sh, my_sh;
	assign mx_sh = cx_q >>> step_q;
	assign my_sh = cy_q >>> step_q;
	// atan step
	logic signed [65:0] ax_sh, ay_sh;
	assign ax_sh = ax_q >>> step_q;
	assign ay_sh = ay_q >>> step_q;

	// trig rounding and clamp
	function automatic logic signed [15:0] trig_round(input logic signed [25:0] v);
		logic signed [25:0] r;
		begin
			r = (v + 26'sd128) >>> 8;
			if (r > 26'sd32767) return 16'sd32767;
			if (r < -26'sd32767) return -16'sd32767;
			return r[15:0];
		end
	endfunction

	// FIR rounding and saturation
	logic signed [47:0] fir_r;
	logic signed [23:0] fir_sat;
	assign fir_r = (acc_q + 48'sd65536) >>> 17;
	assign fir_sat = (fir_r > 48'sd8388607) ? 24'sd8388607 :
		(fir_r < -48'sd8388608) ? -24'sd8388608 : fir_r[23:0];

	logic signed [35:0] mac_p;
	assign mac_p = coef_rd * (chan_q ? qline_rd : iline_rd);

	logic signed [40:0] lvl_full;
	assign lvl_full = ((gp_q + 41'sd32768) >>> 16) + 41'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wpos_q <= '0;
			mixer_phase_q <= '0;
			pi_q <= '0;
			pq_q <= '0;
			out_valid_q <= 1'b0;
			step_q <= '0;
			macn_q <= '0;
			chan_q <= 1'b0;
			tap_q <= '0;
			ridx_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (wpos_q == TapW'(Taps - 1)) begin
						wpos_q <= '0;
						state_q <= ST_IDLE;
					end else
						wpos_q <= wpos_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_acc && in_ch.func == FUNC_SAMPLE) begin
						sample_q <= in_ch.sample;
						mixer_phase_q <= mixer_phase_q - phase_step_q;
						state_q <= ST_MIX;
						step_q <= '0;
						begin
							logic signed [23:0] z;
							z = 24'((mixer_phase_q - phase_step_q) >> 8);
							flip_q <= 1'b0;
							if (z > QuarterTurn) begin
								cz_q <= 26'(z) - HalfTurn;
								flip_q <= 1'b1;
							end else if (z < -QuarterTurn) begin
								cz_q <= 26'(z) + HalfTurn;
								flip_q <= 1'b1;
							end else
								cz_q <= 26'(z);
						end
						cx_q <= 26'sd5093632;
						cy_q <= '0;
					end
				end
				ST_MIX: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - my_sh;
						cy_q <= cy_q + mx_sh;
						cz_q <= cz_q - 26'(atan_turns(step_q));
					end else begin
						cx_q <= cx_q + my_sh;
						cy_q <= cy_q - mx_sh;
						cz_q <= cz_q + 26'(atan_turns(step_q));
					end
					if (step_q == StepW'(CordicSteps - 1)) begin
						state_q <= ST_PROD;
					end
					step_q <= step_q + 1'b1;
				end
				ST_PROD: begin
					// products are formed from cos_q/sin_q set on entry
					state_q <= ST_MAC;
					acc_q <= '0;
					chan_q <= 1'b0;
					macn_q <= '0;
					tap_q <= '0;
					ridx_q <= wpos_q;
				end
				ST_MAC: begin
					// the data phase runs in the cycle after its address phase
					if (macn_q < (TapW+1)'(Taps - 1)) begin
						tap_q <= tap_q + 1'b1;
						ridx_q <= (ridx_q == '0) ? TapW'(Taps - 1) : ridx_q - 1'b1;
					end
					if (macn_q != '0)
						acc_q <= acc_q + 48'(mac_p);
					if (macn_q == (TapW+1)'(Taps))
						state_q <= ST_FIRO;
					macn_q <= macn_q + 1'b1;
				end
				ST_FIRO: begin
					if (!chan_q) begin
						ci_q <= fir_sat;
						chan_q <= 1'b1;
						acc_q <= '0;
						macn_q <= '0;
						tap_q <= '0;
						ridx_q <= wpos_q;
						state_q <= ST_MAC;
					end else begin
						cq_q <= fir_sat;
						wpos_q <= (wpos_q == TapW'(Taps - 1)) ? '0 : wpos_q + 1'b1;
						state_q <= ST_CMUL;
					end
				end
				ST_CMUL: begin
					m0_q <= ci_q * pi_q;
					m1_q <= cq_q * pq_q;
					m2_q <= cq_q * pi_q;
					m3_q <= ci_q * pq_q;
					state_q <= ST_CADD;
				end
				ST_CADD: begin
					pi_q <= ci_q;
					pq_q <= cq_q;
					re_q <= 64'(m0_q) + 64'(m1_q);
					im_q <= 64'(m2_q) - 64'(m3_q);
					step_q <= '0;
					state_q <= ST_ATAN;
					if (64'(m0_q) + 64'(m1_q) < 0) begin
						ax_q <= -(66'(m0_q) + 66'(m1_q));
						ay_q <= -(66'(m2_q) - 66'(m3_q));
						az_q <= (64'(m2_q) - 64'(m3_q) >= 0) ? HalfTurn : -HalfTurn;
					end else begin
						ax_q <= 66'(m0_q) + 66'(m1_q);
						ay_q <= 66'(m2_q) - 66'(m3_q);
						az_q <= '0;
					end
				end
				ST_ATAN: begin
					if (re_q == 0 && im_q == 0) begin
						az_q <= '0;
						state_q <= ST_GAIN;
					end else begin
						if (ay_q >= 0) begin
							ax_q <= ax_q + ay_sh;
							ay_q <= ay_q - ax_sh;
							az_q <= az_q + 26'(atan_turns(step_q));
						end else begin
							ax_q <= ax_q - ay_sh;
							ay_q <= ay_q + ax_sh;
							az_q <= az_q - 26'(atan_turns(step_q));
						end
						step_q <= step_q + 1'b1;
						if (step_q == StepW'(CordicSteps - 1))
							state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					gp_q <= 41'(az_q) * $signed({1'b0, output_gain_q});
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					// hold until the previous level has left
					if (!out_valid_q) begin
						lvl_q <= (lvl_full < 0) ? 16'd0 :
							(lvl_full > 41'sd65535) ? 16'hFFFF : lvl_full[15:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// trig results latched at the end of the mixer rotation
	always_ff @(posedge clk) begin
		if (state_q == ST_MIX && step_q == StepW'(CordicSteps - 1)) begin
			cos_q <= trig_round(flip_q ? -(cz_q >= 0 ? cx_q - my_sh : cx_q + my_sh)
				: (cz_q >= 0 ? cx_q - my_sh : cx_q + my_sh));
			sin_q <= trig_round(flip_q ? -(cz_q >= 0 ? cy_q + mx_sh : cy_q - mx_sh)
				: (cz_q >= 0 ? cy_q + mx_sh : cy_q - mx_sh));
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_level))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> !in_ch.ready)
		else $error("input taken during filter walk");
	a_wpos: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= TapW'(Taps - 1))
		else $error("write position out of range");
`endif
endmodule
